>>> rtl/core/cmm_pkg.sv
// cmm_pkg: shared types and fixed constants for the circular merge cost block.
// Used by the controller, datapath and top level; no dependencies.
package cmm_pkg;

	localparam int WEIGHT_PORT_BITS = 16;
	localparam int COUNT_PORT_BITS  = 8;
	localparam int OUT_BITS         = 30;
	localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

	typedef enum logic [4:0] {
		ST_LOAD   = 5'b00001,
		ST_ISSUE  = 5'b00010,
		ST_WAIT   = 5'b00100,
		ST_WRITE  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // weight word accepted
		logic load_first;  // first weight of the ring
		logic n_one;       // single pile ring: result is zero
		logic issue;       // split point read issued
		logic first;       // first split of this run
		logic last;        // last split of this run
		logic zero_a;      // left part is a single pile
		logic zero_b;      // right part is a single pile
		logic wrap;        // run wraps past the end of the ring
		logic pa_zero;     // run starts at pile 0
		logic write;       // write run cost back
		logic len_is_n;    // run covers whole ring
		logic first_i;     // first start point of the ring
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic acc_done;    // min/max over split points complete
	} sts_t;

endpackage

>>> rtl/core/cmm_in_if.sv
// cmm_in_if: valid/ready channel carrying one pile weight word.
// Depends on cmm_pkg for the payload width.
interface cmm_in_if;
	logic valid;
	logic ready;
	logic [cmm_pkg::WEIGHT_PORT_BITS-1:0] pile_weight;

	modport source (output valid, output pile_weight, input ready);
	modport sink   (input valid, input pile_weight, output ready);
endinterface

>>> rtl/core/cmm_out_if.sv
// cmm_out_if: valid/ready channel carrying the least and greatest ring cost.
// Depends on cmm_pkg for the payload width.
interface cmm_out_if;
	logic valid;
	logic ready;
	logic [cmm_pkg::OUT_BITS-1:0] min_total;
	logic [cmm_pkg::OUT_BITS-1:0] max_total;

	modport source (output valid, output min_total, output max_total, input ready);
	modport sink   (input valid, input min_total, input max_total, output ready);
endinterface

>>> rtl/core/cmm_ctrl.sv
// cmm_ctrl: sequencer for loading and the interval program over the ring.
// Depends on cmm_pkg (state_t, cmd_t, sts_t).
module cmm_ctrl #(
	parameter int MAX_PILES = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [cmm_pkg::COUNT_PORT_BITS-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  cmm_pkg::sts_t sts,
	output cmm_pkg::cmd_t cmd,
	output logic [$clog2(MAX_PILES+1)-1:0] load_addr,
	output logic [$clog2(MAX_PILES+1)-1:0] pa_addr,
	output logic [$clog2(MAX_PILES+1)-1:0] pb_addr,
	output logic [2*$clog2(MAX_PILES)-1:0] a_addr,
	output logic [2*$clog2(MAX_PILES)-1:0] b_addr,
	output logic [2*$clog2(MAX_PILES)-1:0] w_addr
);
	localparam int CNT_BITS = $clog2(MAX_PILES+1);
	localparam int IDX_BITS = $clog2(MAX_PILES);

	cmm_pkg::state_t state_q;
	logic [cmm_pkg::COUNT_PORT_BITS-1:0] pile_count_q;
	logic [CNT_BITS-1:0] l_q, len_q;
	logic [IDX_BITS-1:0] i_q, a_q;

	logic [8:0] pc9;
	logic [CNT_BITS-1:0] n;
	logic [CNT_BITS-1:0] l_next, b_len;
	logic [IDX_BITS:0] ksum;
	logic [IDX_BITS-1:0] k;
	logic [CNT_BITS:0] run_end;
	logic accept;

	// effective ring size: zero reads as one, saturate at MAX_PILES
	always_comb begin
		pc9 = {1'b0, pile_count_q};
		if (pc9 == 9'd0) begin
			n = CNT_BITS'(1);
		end else if (pc9 > 9'(MAX_PILES)) begin
			n = CNT_BITS'(MAX_PILES);
		end else begin
			n = CNT_BITS'(pc9);
		end
	end

	assign accept = in_valid && in_ready;
	assign l_next = l_q + CNT_BITS'(1);
	assign b_len  = len_q - CNT_BITS'(a_q);
	assign ksum   = {1'b0, i_q} + {1'b0, a_q};
	assign k      = ({1'b0, ksum} >= (CNT_BITS+1)'(n)) ?
		IDX_BITS'({1'b0, ksum} - (CNT_BITS+1)'(n)) : ksum[IDX_BITS-1:0];
	assign run_end = (CNT_BITS+1)'(i_q) + (CNT_BITS+1)'(len_q);

	assign load_addr = l_next;
	assign pa_addr   = CNT_BITS'(i_q);
	assign pb_addr   = (run_end > (CNT_BITS+1)'(n)) ?
		CNT_BITS'(run_end - (CNT_BITS+1)'(n)) : CNT_BITS'(run_end);
	assign a_addr    = {i_q, a_q - IDX_BITS'(1)};
	assign b_addr    = {k, IDX_BITS'(b_len - CNT_BITS'(1))};
	assign w_addr    = {i_q, IDX_BITS'(len_q - CNT_BITS'(1))};

	assign in_ready  = (state_q == cmm_pkg::ST_LOAD);
	assign out_valid = (state_q == cmm_pkg::ST_RESULT);

	always_comb begin
		cmd = '0;
		cmd.load       = accept;
		cmd.load_first = (l_q == '0);
		cmd.n_one      = accept && (n == CNT_BITS'(1));
		cmd.issue      = (state_q == cmm_pkg::ST_ISSUE);
		cmd.first      = (a_q == IDX_BITS'(1));
		cmd.last       = (CNT_BITS'(a_q) == len_q - CNT_BITS'(1));
		cmd.zero_a     = (a_q == IDX_BITS'(1));
		cmd.zero_b     = (b_len == CNT_BITS'(1));
		cmd.wrap       = (run_end > (CNT_BITS+1)'(n));
		cmd.pa_zero    = (i_q == '0);
		cmd.write      = (state_q == cmm_pkg::ST_WRITE);
		cmd.len_is_n   = (len_q == n);
		cmd.first_i    = (i_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cmm_pkg::ST_LOAD;
			pile_count_q <= cmm_pkg::COUNT_PORT_BITS'(1);
			l_q          <= '0;
			len_q        <= '0;
			i_q          <= '0;
			a_q          <= '0;
		end else begin
			case (state_q)
				cmm_pkg::ST_LOAD: begin
					if (accept) begin
						if (l_next >= n) begin
							l_q <= '0;
							if (n == CNT_BITS'(1)) begin
								state_q <= cmm_pkg::ST_RESULT;
							end else begin
								i_q     <= '0;
								len_q   <= CNT_BITS'(2);
								a_q     <= IDX_BITS'(1);
								state_q <= cmm_pkg::ST_ISSUE;
							end
						end else begin
							l_q <= l_next;
						end
					end
				end
				cmm_pkg::ST_ISSUE: begin
					if (cmd.last) begin
						state_q <= cmm_pkg::ST_WAIT;
					end else begin
						a_q <= a_q + IDX_BITS'(1);
					end
				end
				cmm_pkg::ST_WAIT: begin
					if (sts.acc_done) begin
						state_q <= cmm_pkg::ST_WRITE;
					end
				end
				cmm_pkg::ST_WRITE: begin
					a_q <= IDX_BITS'(1);
					if (CNT_BITS'(i_q) == n - CNT_BITS'(1)) begin
						i_q <= '0;
						if (len_q == n) begin
							state_q <= cmm_pkg::ST_RESULT;
						end else begin
							len_q   <= len_q + CNT_BITS'(1);
							state_q <= cmm_pkg::ST_ISSUE;
						end
					end else begin
						i_q     <= i_q + IDX_BITS'(1);
						state_q <= cmm_pkg::ST_ISSUE;
					end
				end
				cmm_pkg::ST_RESULT: begin
					if (out_ready) begin
						state_q <= cmm_pkg::ST_LOAD;
					end
				end
				default: begin
					state_q <= cmm_pkg::ST_LOAD;
				end
			endcase
			// a new count drops any partly loaded ring
			if (cfg_we) begin
				pile_count_q <= cfg_data;
				l_q          <= '0;
			end
		end
	end

	a_done_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		sts.acc_done |-> $past(cmd.issue && cmd.last, 3))
		else $error("accumulator done without a matching last split");
	a_wait_before_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> $past(state_q == cmm_pkg::ST_WAIT) && $past(sts.acc_done))
		else $error("run cost written before accumulation finished");
	a_no_load_in_compute: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue || cmd.write || out_valid) |-> !in_ready)
		else $error("weight accepted outside load phase");

endmodule

>>> rtl/core/cmm_dpath.sv
// cmm_dpath: prefix sum store, least/greatest cost tables, split accumulators
// and result registers. Depends on cmm_pkg (cmd_t, sts_t, widths).
module cmm_dpath #(
	parameter int MAX_PILES   = 128,
	parameter int WEIGHT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  cmm_pkg::cmd_t cmd,
	output cmm_pkg::sts_t sts,
	input  logic [cmm_pkg::WEIGHT_PORT_BITS-1:0] pile_weight,
	input  logic [$clog2(MAX_PILES+1)-1:0] load_addr,
	input  logic [$clog2(MAX_PILES+1)-1:0] pa_addr,
	input  logic [$clog2(MAX_PILES+1)-1:0] pb_addr,
	input  logic [2*$clog2(MAX_PILES)-1:0] a_addr,
	input  logic [2*$clog2(MAX_PILES)-1:0] b_addr,
	input  logic [2*$clog2(MAX_PILES)-1:0] w_addr,
	output logic [cmm_pkg::OUT_BITS-1:0] min_total,
	output logic [cmm_pkg::OUT_BITS-1:0] max_total
);
	localparam int CNT_BITS  = $clog2(MAX_PILES+1);
	localparam int IDX_BITS  = $clog2(MAX_PILES);
	localparam int SUM_BITS  = WEIGHT_BITS + CNT_BITS;
	localparam int COST_BITS = SUM_BITS + CNT_BITS;
	localparam int WB        = (WEIGHT_BITS < cmm_pkg::WEIGHT_PORT_BITS) ?
		WEIGHT_BITS : cmm_pkg::WEIGHT_PORT_BITS;
	localparam int WIDE      = (COST_BITS > cmm_pkg::OUT_BITS) ? COST_BITS : cmm_pkg::OUT_BITS;
	localparam int PDEPTH    = MAX_PILES + 1;
	localparam int TDEPTH    = 2 ** (2*IDX_BITS);

	logic [SUM_BITS-1:0]  psum_mem [PDEPTH];
	logic [COST_BITS-1:0] lo_mem [TDEPTH];
	logic [COST_BITS-1:0] hi_mem [TDEPTH];

	logic [SUM_BITS-1:0]  total_q, w_q, weight, sum_new;
	logic [SUM_BITS-1:0]  pa_s1, pb_s1, pa_val;
	logic [COST_BITS-1:0] lo_a_s1, lo_b_s1, hi_a_s1, hi_b_s1;
	logic issue_s1, first_s1, last_s1, zero_a_s1, zero_b_s1, wrap_s1, pa_zero_s1;
	logic [COST_BITS-1:0] lo_sum, hi_sum, lo_sum_s2, hi_sum_s2;
	logic valid_s2, first_s2, last_s2;
	logic [COST_BITS-1:0] acc_lo_q, acc_hi_q, wr_lo, wr_hi, res_lo_q, res_hi_q;
	logic done_q;
	logic [WIDE-1:0] lo_wide, hi_wide;

	assign weight  = SUM_BITS'(pile_weight[WB-1:0]);
	assign sum_new = cmd.load_first ? weight : total_q + weight;

	// prefix sums: entry 0 is never written; a read of it is forced to zero by pa_zero
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			psum_mem[load_addr] <= sum_new;
			total_q             <= sum_new;
		end
		pa_s1 <= psum_mem[pa_addr];
		pb_s1 <= psum_mem[pb_addr];
	end

	// cost tables, indexed {start, length-1}; length one is never stored
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			lo_mem[w_addr] <= wr_lo;
			hi_mem[w_addr] <= wr_hi;
		end
		lo_a_s1 <= lo_mem[a_addr];
		lo_b_s1 <= lo_mem[b_addr];
		hi_a_s1 <= hi_mem[a_addr];
		hi_b_s1 <= hi_mem[b_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
			valid_s2 <= issue_s1;
			done_q   <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1   <= cmd.first;
		last_s1    <= cmd.last;
		zero_a_s1  <= cmd.zero_a;
		zero_b_s1  <= cmd.zero_b;
		wrap_s1    <= cmd.wrap;
		pa_zero_s1 <= cmd.pa_zero;
	end

	assign pa_val = pa_zero_s1 ? '0 : pa_s1;
	assign lo_sum = (zero_a_s1 ? '0 : lo_a_s1) + (zero_b_s1 ? '0 : lo_b_s1);
	assign hi_sum = (zero_a_s1 ? '0 : hi_a_s1) + (zero_b_s1 ? '0 : hi_b_s1);

	always_ff @(posedge clk) begin
		if (issue_s1 && first_s1) begin
			w_q <= wrap_s1 ? total_q - pa_val + pb_s1 : pb_s1 - pa_val;
		end
		lo_sum_s2 <= lo_sum;
		hi_sum_s2 <= hi_sum;
		first_s2  <= first_s1;
		last_s2   <= last_s1;
		if (valid_s2) begin
			if (first_s2 || lo_sum_s2 < acc_lo_q) begin
				acc_lo_q <= lo_sum_s2;
			end
			if (first_s2 || hi_sum_s2 > acc_hi_q) begin
				acc_hi_q <= hi_sum_s2;
			end
		end
	end

	assign wr_lo = acc_lo_q + COST_BITS'(w_q);
	assign wr_hi = acc_hi_q + COST_BITS'(w_q);

	// best over start points, taken as whole-ring runs are written
	always_ff @(posedge clk) begin
		if (cmd.n_one) begin
			res_lo_q <= '0;
			res_hi_q <= '0;
		end else if (cmd.write && cmd.len_is_n) begin
			if (cmd.first_i || wr_lo < res_lo_q) begin
				res_lo_q <= wr_lo;
			end
			if (cmd.first_i || wr_hi > res_hi_q) begin
				res_hi_q <= wr_hi;
			end
		end
	end

	assign sts.acc_done = done_q;

	assign lo_wide   = WIDE'(res_lo_q);
	assign hi_wide   = WIDE'(res_hi_q);
	assign min_total = (lo_wide > WIDE'(cmm_pkg::OUT_MAX)) ? cmm_pkg::OUT_MAX :
		lo_wide[cmm_pkg::OUT_BITS-1:0];
	assign max_total = (hi_wide > WIDE'(cmm_pkg::OUT_MAX)) ? cmm_pkg::OUT_MAX :
		hi_wide[cmm_pkg::OUT_BITS-1:0];

endmodule

>>> rtl/core/circular_merge_cost_min_max.sv
// Circular pile merge cost, least and greatest. Weights load at one word per cycle
// while pile.ready is high; after the last weight of a ring of n piles the block
// computes every run of length 2..n at every start point, one split point per cycle
// through the dual-read cost tables, then drains the read and accumulate stages
// and writes the run cost back. One result word follows; for a single pile it
// comes in the cycle after the weight. No clearing pass is needed after reset.
// Depends on cmm_pkg, cmm_in_if, cmm_out_if, cmm_ctrl and cmm_dpath.
module circular_merge_cost_min_max #(
	parameter int MAX_PILES   = 128,
	parameter int WEIGHT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [cmm_pkg::COUNT_PORT_BITS-1:0] cfg_data,
	cmm_in_if.sink    pile,
	cmm_out_if.source result
);
	localparam int CNT_BITS = $clog2(MAX_PILES+1);
	localparam int IDX_BITS = $clog2(MAX_PILES);

	cmm_pkg::cmd_t cmd;
	cmm_pkg::sts_t sts;
	logic [CNT_BITS-1:0] load_addr, pa_addr, pb_addr;
	logic [2*IDX_BITS-1:0] a_addr, b_addr, w_addr;

	cmm_ctrl #(.MAX_PILES(MAX_PILES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (pile.valid),
		.in_ready  (pile.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd),
		.load_addr (load_addr),
		.pa_addr   (pa_addr),
		.pb_addr   (pb_addr),
		.a_addr    (a_addr),
		.b_addr    (b_addr),
		.w_addr    (w_addr)
	);

	cmm_dpath #(.MAX_PILES(MAX_PILES), .WEIGHT_BITS(WEIGHT_BITS)) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.pile_weight (pile.pile_weight),
		.load_addr   (load_addr),
		.pa_addr     (pa_addr),
		.pb_addr     (pb_addr),
		.a_addr      (a_addr),
		.b_addr      (b_addr),
		.w_addr      (w_addr),
		.min_total   (result.min_total),
		.max_total   (result.max_total)
	);

endmodule
